>>> sv/aes_pkg.sv
// Shared types, tables and round functions for the AES-128 encryption pipeline.
// No dependencies; used by aes_round and aes128_block_encrypt_unit.
`default_nettype none
package aes_pkg;

  localparam int NUM_ROUNDS = 10;

  typedef struct packed {
    logic [127:0] state;
    logic [127:0] key;
  } aes_word_t;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int n = 0; n < 16; n++) begin
      t[127-8*n -: 8] = SBOX[s[127-8*n -: 8]];
    end
    sub_bytes = t;
  endfunction

  // byte r+4c of the result takes byte r+4((c+r) mod 4)
  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    mix_column = {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                  a0 ^ d1 ^ d2 ^ a2 ^ a3,
                  a0 ^ a1 ^ d2 ^ d3 ^ a3,
                  d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = mix_column(s[127-32*c -: 32]);
    end
    mix_columns = t;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rcon);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h000000};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    next_round_key = {n0, n1, n2, n3};
  endfunction

endpackage
`default_nettype wire

>>> sv/aes_round.sv
// One registered AES round stage: round transform plus the matching key schedule step.
// Depends on aes_pkg.
`default_nettype none
module aes_round (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               up_valid,
  input  wire aes_pkg::aes_word_t up_word,
  input  wire logic [7:0]         rcon,
  input  wire logic               final_round,
  output logic                    valid_r,
  output aes_pkg::aes_word_t      word_r
);
  import aes_pkg::*;

  logic [127:0] key_nxt;
  logic [127:0] shifted;
  logic [127:0] mixed;
  aes_word_t    word_nxt;

  always_comb begin
    key_nxt        = next_round_key(up_word.key, rcon);
    shifted        = shift_rows(sub_bytes(up_word.state));
    mixed          = final_round ? shifted : mix_columns(shifted);
    word_nxt.state = mixed ^ key_nxt;
    word_nxt.key   = key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/aes128_block_encrypt_unit.sv
// AES-128 encryption pipeline top level: input AddRoundKey stage and ten round stages.
// Depends on aes_pkg and aes_round.
//
//   channel | direction | tdata fields (lowest bit up)
//   in_     | slave     | plaintext_hi, plaintext_lo, key_hi, key_lo (256 bits)
//   out_    | master    | ciphertext_hi, ciphertext_lo (128 bits)
//
// Eleven register stages: whitening, then one round per stage.
// One word per cycle in and out while out_tready is high; each round stage holds one
// SubBytes/ShiftRows/MixColumns/AddRoundKey plus one key schedule step.
// A stage advances when it is empty or the stage after it advances, so bubbles close
// up during a stall. Reset clears the valid bits only.
`default_nettype none
module aes128_block_encrypt_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [255:0] in_tdata,   // plaintext_hi, plaintext_lo, key_hi, key_lo
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // ciphertext_hi, ciphertext_lo
);
  import aes_pkg::*;

  logic [NUM_ROUNDS:0]   valid;
  logic [NUM_ROUNDS+1:0] ready;
  aes_word_t             stage [NUM_ROUNDS+1];
  logic                  valid0_r;
  aes_word_t             word0_r;
  aes_word_t             word0_nxt;

  assign ready[NUM_ROUNDS+1] = out_tready;

  for (genvar g = 0; g <= NUM_ROUNDS; g++) begin : g_ready
    assign ready[g] = !valid[g] || ready[g+1];
  end

  assign in_tready = ready[0];

  always_comb begin
    word0_nxt.key   = {in_tdata[191:128], in_tdata[255:192]};
    word0_nxt.state = {in_tdata[63:0], in_tdata[127:64]} ^ word0_nxt.key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (ready[0]) begin
      valid0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      word0_r <= word0_nxt;
    end
  end

  assign valid[0] = valid0_r;
  assign stage[0] = word0_r;

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    aes_round u_round (
      .clk         (clk),
      .rst_n       (rst_n),
      .load        (ready[g]),
      .up_valid    (valid[g-1]),
      .up_word     (stage[g-1]),
      .rcon        (RCON[g-1]),
      .final_round (g == NUM_ROUNDS),
      .valid_r     (valid[g]),
      .word_r      (stage[g])
    );
  end

  assign out_tvalid = valid[NUM_ROUNDS];
  assign out_tdata  = {stage[NUM_ROUNDS].state[63:0], stage[NUM_ROUNDS].state[127:64]};

endmodule
`default_nettype wire

>>> tb/sv/tb_aes128_block_encrypt_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for aes128_block_encrypt_unit: random stream stalls on both sides,
// every ciphertext word checked against an in-bench AES-128 predictor.
// Depends only on the RTL under sv/ (aes_pkg, aes_round, aes128_block_encrypt_unit).
module tb_aes128_block_encrypt_unit;

  typedef struct packed {
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } plain_block_t;

  typedef struct packed {
    logic [63:0] ct_hi;
    logic [63:0] ct_lo;
  } cipher_block_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;   // plaintext_hi, plaintext_lo, key_hi, key_lo
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // ciphertext_hi, ciphertext_lo

  logic [7:0]    sbox_tab [256];
  cipher_block_t ciphertext_q [$];
  cipher_block_t expected_ct;
  int unsigned   mismatch_count;
  int unsigned   in_gap_mode;

  aes128_block_encrypt_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // build the S-box from the field inverse and the affine map
  initial begin
    logic [7:0] inv_v, prod, xa, bv;
    for (int x = 0; x < 256; x++) begin
      inv_v = 8'h00;
      for (int y = 1; y < 256; y++) begin
        prod = 8'h00;
        xa   = 8'(x);
        for (int i = 0; i < 8; i++) begin
          if (y[i]) prod = prod ^ xa;
          xa = gf_double(xa);
        end
        if (prod == 8'h01) inv_v = 8'(y);
      end
      bv = inv_v;
      sbox_tab[x] = bv ^ {bv[6:0], bv[7]} ^ {bv[5:0], bv[7:6]} ^ {bv[4:0], bv[7:5]} ^
                    {bv[3:0], bv[7:4]} ^ 8'h63;
    end
  end

  function automatic cipher_block_t encrypt_block(input plain_block_t b);
    logic [7:0]    st [16];
    logic [7:0]    sh [16];
    logic [31:0]   rk [44];
    logic [31:0]   t;
    logic [7:0]    rc;
    logic [7:0]    a0, a1, a2, a3;
    cipher_block_t res;
    for (int n = 0; n < 8; n++) begin
      st[n]     = b.pt_hi[63-8*n -: 8];
      st[n + 8] = b.pt_lo[63-8*n -: 8];
    end
    rk[0] = b.key_hi[63:32];
    rk[1] = b.key_hi[31:0];
    rk[2] = b.key_lo[63:32];
    rk[3] = b.key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = rk[i-1];
      if (i % 4 == 0) begin
        t = {sbox_tab[t[23:16]], sbox_tab[t[15:8]], sbox_tab[t[7:0]], sbox_tab[t[31:24]]} ^
            {rc, 24'h000000};
        rc = gf_double(rc);
      end
      rk[i] = rk[i-4] ^ t;
    end
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int n = 0; n < 16; n++) sh[n] = sbox_tab[st[n]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) st[r + 4*c] = sh[r + 4*((c + r) % 4)];
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c];
            a1 = st[4*c + 1];
            a2 = st[4*c + 2];
            a3 = st[4*c + 3];
            st[4*c]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
            st[4*c + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
            st[4*c + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
            st[4*c + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[r + 4*c] = st[r + 4*c] ^ rk[4*rnd + c][31-8*r -: 8];
    end
    for (int n = 0; n < 8; n++) begin
      res.ct_hi[63-8*n -: 8] = st[n];
      res.ct_lo[63-8*n -: 8] = st[n + 8];
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
    end
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_field();
    logic [63:0] v;
    int unsigned pos;
    pos = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'(1) << pos;
      3: v = ~(64'(1) << pos);
      4: begin
        v = '0;
        v[(pos & 56) +: 8] = 8'($urandom);
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_block(input plain_block_t b);
    int unsigned gap;
    gap = pick_gap(in_gap_mode);
    @(negedge clk);
    repeat (gap) begin
      in_tvalid = 1'b0;
      in_tdata  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom};
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {b.key_lo, b.key_hi, b.pt_lo, b.pt_hi};
    do @(posedge clk); while (!in_tready);
    ciphertext_q.push_back(encrypt_block(b));
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (ciphertext_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_known_answers();
    plain_block_t  kat [2];
    cipher_block_t kat_ct [2];
    cipher_block_t ct;
    kat[0]    = {128'h00112233445566778899aabbccddeeff, 128'h000102030405060708090a0b0c0d0e0f};
    kat_ct[0] = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
    kat[1]    = {128'h3243f6a8885a308d313198a2e0370734, 128'h2b7e151628aed2a6abf7158809cf4f3c};
    kat_ct[1] = 128'h3925841d02dc09fbdc118597196a0b32;
    in_gap_mode = 0;
    for (int i = 0; i < 2; i++) begin
      ct = encrypt_block(kat[i]);
      if (ct !== kat_ct[i]) begin
        $error("predictor known answer: expected %h, got %h", kat_ct[i], ct);
        mismatch_count++;
      end
      send_block(kat[i]);
    end
  endtask

  task automatic test_field_extremes();
    plain_block_t b;
    in_gap_mode = 1;
    send_block('0);
    send_block('1);
    send_block({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
    send_block({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    // one field all ones, one lone bit at either end of each field
    for (int f = 0; f < 4; f++) begin
      b = '0;
      b[64*f +: 64] = '1;
      send_block(b);
      b = '0;
      b[64*f] = 1'b1;
      send_block(b);
      b = '0;
      b[64*f + 63] = 1'b1;
      send_block(b);
    end
  endtask

  task automatic test_random_blocks(input int unsigned count);
    plain_block_t b;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) in_gap_mode = $urandom_range(0, 2);
      b.pt_hi  = rand_field();
      b.pt_lo  = rand_field();
      b.key_hi = rand_field();
      b.key_lo = rand_field();
      send_block(b);
    end
  endtask

  task automatic test_shared_key_stream(input int unsigned count);
    plain_block_t b;
    int unsigned  run_left;
    run_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left    = $urandom_range(8, 48);
        in_gap_mode = $urandom_range(0, 1);
        b.key_hi    = rand_field();
        b.key_lo    = rand_field();
      end
      run_left--;
      // hold off until the pipeline has emptied
      if (i == count / 2) wait_until_drained();
      b.pt_hi = rand_field();
      b.pt_lo = rand_field();
      send_block(b);
    end
  endtask

  task automatic test_repeated_bytes(input int unsigned count);
    plain_block_t b;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 30 == 0) in_gap_mode = $urandom_range(0, 2);
      for (int f = 0; f < 4; f++)
        b[64*f +: 64] = ($urandom_range(0, 1) == 0) ? {8{8'($urandom)}} : rand_field();
      send_block(b);
    end
  endtask

  initial begin
    int unsigned ready_mode, mode_left, stall_left;
    out_tready = 1'b0;
    mode_left  = 0;
    stall_left = 0;
    ready_mode = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left > 0) begin
          out_tready = 1'b0;
          stall_left--;
        end else begin
          out_tready = 1'b1;
          stall_left = pick_gap(ready_mode);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (ciphertext_q.size() == 0) begin
        $error("ciphertext word with no block pending: %h", out_tdata);
        mismatch_count++;
      end else begin
        expected_ct = ciphertext_q.pop_front();
        if (out_tdata[63:0] !== expected_ct.ct_hi) begin
          $error("ciphertext_hi: expected %h, got %h", expected_ct.ct_hi, out_tdata[63:0]);
          mismatch_count++;
        end
        if (out_tdata[127:64] !== expected_ct.ct_lo) begin
          $error("ciphertext_lo: expected %h, got %h", expected_ct.ct_lo, out_tdata[127:64]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_gap_mode    = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_known_answers();
    test_field_extremes();
    test_random_blocks(350);
    test_shared_key_stream(250);
    test_repeated_bytes(150);

    wait_until_drained();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && ciphertext_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
